// ----- hw/rtl/mseu_pkg.sv -----
// Shared types, opcodes and status codes for the MIPS subset execute unit.
package mseu_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DIVZ   = 2'd1;
  localparam logic [1:0] ST_REFUSE = 2'd2;
  localparam logic [1:0] ST_UNK    = 2'd3;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV  = 6'h1a;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_SLT  = 6'h2a;

  localparam logic [4:0]  LINK_REG   = 5'd31;
  localparam logic [31:0] ALIGN_MASK = 32'hfffffffc;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    logic        mem_written;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// ----- hw/rtl/mseu_div.sv -----
// Iterative signed divider, one quotient bit per cycle.
module mseu_div (
  input  logic               clk,
  input  logic               rst_n,
  input  mseu_pkg::div_req_t req,
  output mseu_pkg::div_rsp_t rsp
);
  logic [31:0] q_r, q_nxt, d_r, d_nxt;
  logic [32:0] r_r, r_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, na_r, na_nxt, nq_r, nq_nxt, done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] sh;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; r_nxt = r_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; na_nxt = na_r; nq_nxt = nq_r; done_nxt = 1'b0;
    sh = {r_r[31:0], q_r[31]};
    trial = sh - {1'b0, d_r};
    if (req.start) begin
      na_nxt = req.dividend[31];
      nq_nxt = req.dividend[31] ^ req.divisor[31];
      q_nxt = req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
      d_nxt = req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
      r_nxt = '0;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        r_nxt = trial;
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        r_nxt = sh;
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; r_r <= r_nxt; na_r <= na_nxt; nq_r <= nq_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = nq_r ? (32'd0 - q_r) : q_r;
  assign rsp.rem  = na_r ? (32'd0 - r_r[31:0]) : r_r[31:0];
endmodule

// ----- hw/rtl/mips_subset_execute_unit.sv -----
// Top level of the MIPS subset execute unit.
// Steps: read rs, read rt, execute/memory read, write back; mult and div add a wait
// state before write back (not for a divide by zero), div waiting there for the iterative divider.
// An item is accepted only once the previous one has left write back; a result waiting
// on out_tready holds the next item in write back.
// Reset: synchronous active-low rst_n; HI, LO and PC clear at once, registers clear
// one by one after reset, no item is accepted meanwhile. Data memory is not cleared.
module mips_subset_execute_unit #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // instr
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], next_pc[33:2], reg_written[34], reg_index[39:35], reg_value[71:40],
  // hi_value[103:72], lo_value[135:104], mem_written[136], mem_address[168:137],
  // mem_data[200:169], zero fill [207:201]
  output logic [207:0] out_tdata
);
  localparam int AW = $clog2(DMEM_WORDS);

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RDA  = 7'b0000100,
    S_RDB  = 7'b0001000,
    S_EXE  = 7'b0010000,
    S_WAIT = 7'b0100000,
    S_WB   = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [4:0]  clr_r, clr_nxt;
  logic        imode_r;
  logic [31:0] instr_r, a_r, b_r, hi_r, lo_r, pc_r;
  logic [31:0] hi_nxt, lo_nxt, pc_nxt;
  logic [63:0] prod_r;
  logic        mul_pend_r, mul_pend_nxt;
  logic        ovalid_r;
  logic        wb_go;
  mseu_pkg::result_t res_r, res_nxt, out_r;

  logic [31:0] gpr [32];
  logic [31:0] gpr_q;
  logic [4:0]  gpr_ra;
  logic        gpr_we;
  logic [4:0]  gpr_wa;
  logic [31:0] gpr_wd;

  logic [31:0] dmem [DMEM_WORDS];
  logic [31:0] dmem_q;
  logic        dmem_we;
  logic [AW-1:0] dmem_a;

  mseu_pkg::div_req_t dreq;
  mseu_pkg::div_rsp_t drsp;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] imm, pc4, btgt, jtgt, addr;

  assign op = instr_r[31:26];
  assign rs = instr_r[25:21];
  assign rt = instr_r[20:16];
  assign rd = instr_r[15:11];
  assign sa = instr_r[10:6];
  assign fn = instr_r[5:0];
  assign imm = {{16{instr_r[15]}}, instr_r[15:0]};
  assign pc4 = pc_r + 32'd4;
  assign btgt = pc4 + {imm[29:0], 2'b00};
  assign jtgt = {pc4[31:28], instr_r[25:0], 2'b00};
  assign addr = a_r + imm;

  // write back completes once the output register is free
  assign wb_go = (state_r == S_WB) && (!ovalid_r || out_tready);

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'd0, out_r.mem_data, out_r.mem_address, out_r.mem_written,
                       out_r.lo_value, out_r.hi_value, out_r.reg_value, out_r.reg_index,
                       out_r.reg_written, out_r.next_pc, out_r.status};

  assign gpr_ra = (state_r == S_IDLE) ? in_tdata[25:21] : rt;
  assign dmem_a = addr[AW+1:2];

  always_ff @(posedge clk) begin
    if (gpr_we) gpr[gpr_wa] <= gpr_wd;
    gpr_q <= (gpr_ra == 5'd0) ? 32'd0 : gpr[gpr_ra];
  end

  always_ff @(posedge clk) begin
    if (dmem_we) dmem[dmem_a] <= b_r;
    dmem_q <= dmem[dmem_a];
  end

  mseu_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    logic is_jump, wr, bad;
    logic [1:0] st;
    state_nxt = state_r;
    clr_nxt = clr_r;
    res_nxt = res_r;
    hi_nxt = hi_r; lo_nxt = lo_r; pc_nxt = pc_r;
    mul_pend_nxt = 1'b0;
    gpr_we = 1'b0; gpr_wa = res_r.reg_index; gpr_wd = res_r.reg_value;
    dmem_we = 1'b0;
    dreq = '0;
    is_jump = 1'b0; wr = 1'b0; bad = 1'b0; st = mseu_pkg::ST_OK;
    unique case (state_r)
      S_CLR: begin
        gpr_we = 1'b1; gpr_wa = clr_r; gpr_wd = '0;
        clr_nxt = clr_r + 5'd1;
        if (clr_r == 5'd31) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_RDA;
      S_RDA: state_nxt = S_RDB;
      S_RDB: state_nxt = S_EXE;
      S_EXE: begin
        res_nxt = '0;
        res_nxt.next_pc = pc4;
        if (op == mseu_pkg::OP_SPECIAL) begin
          res_nxt.reg_index = rd;
          unique case (fn)
            mseu_pkg::FN_ADD: begin wr = 1'b1; res_nxt.reg_value = a_r + b_r; end
            mseu_pkg::FN_SUB: begin wr = 1'b1; res_nxt.reg_value = a_r - b_r; end
            mseu_pkg::FN_AND: begin wr = 1'b1; res_nxt.reg_value = a_r & b_r; end
            mseu_pkg::FN_OR:  begin wr = 1'b1; res_nxt.reg_value = a_r | b_r; end
            mseu_pkg::FN_XOR: begin wr = 1'b1; res_nxt.reg_value = a_r ^ b_r; end
            mseu_pkg::FN_SLT: begin
              wr = 1'b1;
              res_nxt.reg_value = {31'd0, $signed(a_r) < $signed(b_r)};
            end
            mseu_pkg::FN_SLL: begin wr = 1'b1; res_nxt.reg_value = b_r << sa; end
            mseu_pkg::FN_SRL: begin
              if (rs == 5'd0) begin
                wr = 1'b1; res_nxt.reg_value = b_r >> sa;
              end else if (rs == 5'd1) begin
                wr = 1'b1;
                res_nxt.reg_value = (b_r >> sa) | (b_r << (5'd0 - sa));
              end else bad = 1'b1;
            end
            mseu_pkg::FN_MFHI: begin wr = 1'b1; res_nxt.reg_value = hi_r; end
            mseu_pkg::FN_MFLO: begin wr = 1'b1; res_nxt.reg_value = lo_r; end
            mseu_pkg::FN_MULT: mul_pend_nxt = 1'b1;
            mseu_pkg::FN_DIV: begin
              if (b_r == 32'd0) st = mseu_pkg::ST_DIVZ;
              else begin
                dreq.start = 1'b1; dreq.dividend = a_r; dreq.divisor = b_r;
              end
            end
            mseu_pkg::FN_JR: begin
              is_jump = 1'b1; res_nxt.next_pc = a_r & mseu_pkg::ALIGN_MASK;
            end
            default: bad = 1'b1;
          endcase
        end else begin
          res_nxt.reg_index = rt;
          unique case (op)
            mseu_pkg::OP_ADDI: begin wr = 1'b1; res_nxt.reg_value = addr; end
            mseu_pkg::OP_LUI: begin wr = 1'b1; res_nxt.reg_value = {instr_r[15:0], 16'd0}; end
            mseu_pkg::OP_LW: begin wr = 1'b1; res_nxt.mem_address = addr; end
            mseu_pkg::OP_SW: begin
              res_nxt.mem_written = 1'b1; res_nxt.mem_address = addr; res_nxt.mem_data = b_r;
            end
            mseu_pkg::OP_BEQ: begin is_jump = 1'b1; if (a_r == b_r) res_nxt.next_pc = btgt; end
            mseu_pkg::OP_BNE: begin is_jump = 1'b1; if (a_r != b_r) res_nxt.next_pc = btgt; end
            mseu_pkg::OP_BLEZ: begin
              is_jump = 1'b1; if ($signed(a_r) <= 0) res_nxt.next_pc = btgt;
            end
            mseu_pkg::OP_BGTZ: begin
              is_jump = 1'b1; if ($signed(a_r) > 0) res_nxt.next_pc = btgt;
            end
            mseu_pkg::OP_J: begin is_jump = 1'b1; res_nxt.next_pc = jtgt; end
            mseu_pkg::OP_JAL: begin
              is_jump = 1'b1; res_nxt.next_pc = jtgt;
              wr = 1'b1; res_nxt.reg_index = mseu_pkg::LINK_REG; res_nxt.reg_value = pc4;
            end
            default: bad = 1'b1;
          endcase
        end
        if (bad) st = mseu_pkg::ST_UNK;
        else if (is_jump && imode_r) st = mseu_pkg::ST_REFUSE;
        res_nxt.status = st;
        if (st[1]) begin
          wr = 1'b0; res_nxt.mem_written = 1'b0;
          res_nxt.next_pc = pc_r; res_nxt.mem_address = '0; res_nxt.mem_data = '0;
          mul_pend_nxt = 1'b0; dreq.start = 1'b0;
        end
        if (!wr || res_nxt.reg_index == 5'd0) begin
          res_nxt.reg_written = 1'b0; res_nxt.reg_index = '0; res_nxt.reg_value = '0;
        end else res_nxt.reg_written = 1'b1;
        dmem_we = res_nxt.mem_written;
        state_nxt = (dreq.start || mul_pend_nxt) ? S_WAIT : S_WB;
      end
      S_WAIT: begin
        if (mul_pend_r) begin
          hi_nxt = prod_r[63:32]; lo_nxt = prod_r[31:0]; state_nxt = S_WB;
        end else if (drsp.done) begin
          hi_nxt = drsp.rem; lo_nxt = drsp.quot; state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (op == mseu_pkg::OP_LW && res_r.status == mseu_pkg::ST_OK) begin
          res_nxt.mem_data = dmem_q;
          if (res_r.reg_written) res_nxt.reg_value = dmem_q;
        end
        res_nxt.hi_value = hi_r; res_nxt.lo_value = lo_r;
        if (wb_go) begin
          gpr_we = res_nxt.reg_written; gpr_wa = res_nxt.reg_index; gpr_wd = res_nxt.reg_value;
          pc_nxt = res_r.next_pc;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      imode_r <= 1'b0;
      hi_r <= '0; lo_r <= '0; pc_r <= '0;
      ovalid_r <= 1'b0;
      mul_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      if (cfg_valid && cfg_ready) imode_r <= cfg_data;
      hi_r <= hi_nxt; lo_r <= lo_nxt; pc_r <= pc_nxt;
      mul_pend_r <= (state_r == S_EXE) ? mul_pend_nxt : 1'b0;
      if (wb_go) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (wb_go) out_r <= res_nxt;
    if (in_tvalid && in_tready) instr_r <= in_tdata;
    if (state_r == S_RDA) a_r <= gpr_q;
    if (state_r == S_RDB) b_r <= gpr_q;
    if (state_r == S_EXE) prod_r <= $signed(a_r) * $signed(b_r);
  end
endmodule

// ----- hw/rtl/mseu_checker.sv -----
// Port-level checker for the MIPS subset execute unit, with its bind.
module mseu_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [207:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while busy");
  a_no_write_on_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[34] && !out_tdata[136])
    else $error("write reported on refused or unknown item");
  a_r0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34] |-> out_tdata[39:35] != 5'd0)
    else $error("write to r0 reported");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[207:201] == 7'd0)
    else $error("fill bits set");
endmodule

bind mips_subset_execute_unit mseu_checker u_mseu_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ----- test/mips_subset_execute_unit_tb.sv -----
// Testbench for the MIPS subset execute unit: directed table, then predicted random programs.
`timescale 1ns / 100ps

module mips_subset_execute_unit_tb;

  localparam int DMEM_WORDS = 1024;
  localparam int N_PHASES   = 5;
  localparam int PHASE_LEN  = 374;
  localparam int CYCLE_CAP  = 1500000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_data = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [207:0] out_tdata;

  mips_subset_execute_unit #(.DMEM_WORDS(DMEM_WORDS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q, pc_q;
  logic [31:0] dmem [DMEM_WORDS];
  bit          dmem_set [DMEM_WORDS];
  int          dmem_used [$];
  logic        refuse_jumps;

  mseu_pkg::result_t exp_results [$];
  int      n_fail = 0;
  int      n_seen = 0;
  int      n_sent = 0;
  int      cycles = 0;
  int      n_div0 = 0, n_refused = 0, n_unknown = 0;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sa);
    return {mseu_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // executes one instruction word on the shadow state, returns the expected item
  function automatic mseu_pkg::result_t execute_instr(logic [31:0] w);
    mseu_pkg::result_t r;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa, widx;
    logic [31:0] a, b, imm, pc4, npc, wval, maddr, mdata, ua, ub, q, rm;
    logic [1:0]  st;
    logic        wr, mw, jmp, na, nb;
    longint      prod;
    int          k;
    op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sa = w[10:6]; fn = w[5:0];
    a = gpr[rs]; b = gpr[rt]; imm = sx16(w[15:0]); pc4 = pc_q + 32'd4;
    st = mseu_pkg::ST_OK; npc = pc4; wr = 1'b0; mw = 1'b0; jmp = 1'b0;
    widx = '0; wval = '0; maddr = '0; mdata = '0;
    if (op == mseu_pkg::OP_SPECIAL) begin
      case (fn)
        mseu_pkg::FN_ADD: begin wr = 1'b1; widx = rd; wval = a + b; end
        mseu_pkg::FN_SUB: begin wr = 1'b1; widx = rd; wval = a - b; end
        mseu_pkg::FN_AND: begin wr = 1'b1; widx = rd; wval = a & b; end
        mseu_pkg::FN_OR:  begin wr = 1'b1; widx = rd; wval = a | b; end
        mseu_pkg::FN_XOR: begin wr = 1'b1; widx = rd; wval = a ^ b; end
        mseu_pkg::FN_SLT: begin
          wr = 1'b1; widx = rd; wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        end
        mseu_pkg::FN_SLL: begin wr = 1'b1; widx = rd; wval = b << sa; end
        mseu_pkg::FN_SRL: begin
          if (rs == 5'd0) begin
            wr = 1'b1; widx = rd; wval = b >> sa;
          end else if (rs == 5'd1) begin
            wr = 1'b1; widx = rd;
            wval = (sa != 5'd0) ? ((b >> sa) | (b << (5'd0 - sa))) : b;
          end else begin
            st = mseu_pkg::ST_UNK;
          end
        end
        mseu_pkg::FN_MFHI: begin wr = 1'b1; widx = rd; wval = hi_q; end
        mseu_pkg::FN_MFLO: begin wr = 1'b1; widx = rd; wval = lo_q; end
        mseu_pkg::FN_MULT: begin
          prod = longint'($signed(a)) * longint'($signed(b));
          hi_q = prod[63:32]; lo_q = prod[31:0];
        end
        mseu_pkg::FN_DIV: begin
          if (b == 32'd0) begin
            st = mseu_pkg::ST_DIVZ;
          end else begin
            na = a[31]; nb = b[31];
            ua = na ? -a : a; ub = nb ? -b : b;
            q = ua / ub; rm = ua % ub;
            lo_q = (na != nb) ? -q : q;
            hi_q = na ? -rm : rm;
          end
        end
        mseu_pkg::FN_JR: begin jmp = 1'b1; npc = a & mseu_pkg::ALIGN_MASK; end
        default: st = mseu_pkg::ST_UNK;
      endcase
    end else begin
      case (op)
        mseu_pkg::OP_ADDI: begin wr = 1'b1; widx = rt; wval = a + imm; end
        mseu_pkg::OP_LUI:  begin wr = 1'b1; widx = rt; wval = {w[15:0], 16'h0}; end
        mseu_pkg::OP_LW: begin
          maddr = a + imm; k = (maddr >> 2) % DMEM_WORDS;
          mdata = dmem[k]; wr = 1'b1; widx = rt; wval = mdata;
        end
        mseu_pkg::OP_SW:   begin maddr = a + imm; mdata = b; mw = 1'b1; end
        mseu_pkg::OP_BEQ:  begin jmp = 1'b1; if (a == b) npc = pc4 + (imm << 2); end
        mseu_pkg::OP_BNE:  begin jmp = 1'b1; if (a != b) npc = pc4 + (imm << 2); end
        mseu_pkg::OP_BLEZ: begin jmp = 1'b1; if ($signed(a) <= 0) npc = pc4 + (imm << 2); end
        mseu_pkg::OP_BGTZ: begin jmp = 1'b1; if ($signed(a) > 0) npc = pc4 + (imm << 2); end
        mseu_pkg::OP_J:    begin jmp = 1'b1; npc = {pc4[31:28], w[25:0], 2'b00}; end
        mseu_pkg::OP_JAL: begin
          jmp = 1'b1; npc = {pc4[31:28], w[25:0], 2'b00};
          wr = 1'b1; widx = mseu_pkg::LINK_REG; wval = pc4;
        end
        default: st = mseu_pkg::ST_UNK;
      endcase
    end
    if (jmp && refuse_jumps) begin st = mseu_pkg::ST_REFUSE; wr = 1'b0; end
    if (st >= mseu_pkg::ST_REFUSE) begin
      wr = 1'b0; mw = 1'b0; npc = pc_q; maddr = '0; mdata = '0;
    end
    if (wr && widx == 5'd0) wr = 1'b0;
    if (wr) gpr[widx] = wval;
    else begin widx = '0; wval = '0; end
    if (mw) begin
      k = (maddr >> 2) % DMEM_WORDS;
      dmem[k] = mdata;
      if (!dmem_set[k]) begin dmem_set[k] = 1'b1; dmem_used.push_back(k); end
    end
    pc_q = npc;
    r.status = st; r.next_pc = npc; r.reg_written = wr; r.reg_index = widx;
    r.reg_value = wval; r.hi_value = hi_q; r.lo_value = lo_q; r.mem_written = mw;
    r.mem_address = maddr; r.mem_data = mdata;
    return r;
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [4:0]  rs, rt, rd, sa;
    logic [15:0] imm;
    logic [31:0] w;
    int          k;
    rs = 5'($urandom_range(0, 31)); rt = 5'($urandom_range(0, 31));
    rd = 5'($urandom_range(0, 31)); sa = 5'($urandom_range(0, 31));
    imm = 16'($urandom);
    // now and then take r0 as rs, so load and store addresses come from the offset alone
    if ($urandom_range(0, 3) == 0) rs = 5'd0;
    case ($urandom_range(0, 27))
      0:  w = rtype(mseu_pkg::FN_ADD, rs, rt, rd, sa);
      1:  w = rtype(mseu_pkg::FN_SUB, rs, rt, rd, sa);
      2:  w = rtype(mseu_pkg::FN_AND, rs, rt, rd, sa);
      3:  w = rtype(mseu_pkg::FN_OR, rs, rt, rd, sa);
      4:  w = rtype(mseu_pkg::FN_XOR, rs, rt, rd, sa);
      5:  w = rtype(mseu_pkg::FN_SLT, rs, rt, rd, sa);
      6:  w = rtype(mseu_pkg::FN_SLL, rs, rt, rd, sa);
      7:  w = rtype(mseu_pkg::FN_SRL, 5'd0, rt, rd, sa);
      8:  w = rtype(mseu_pkg::FN_SRL, 5'd1, rt, rd, sa);
      9:  w = rtype(mseu_pkg::FN_MFHI, rs, rt, rd, sa);
      10: w = rtype(mseu_pkg::FN_MFLO, rs, rt, rd, sa);
      11: w = rtype(mseu_pkg::FN_MULT, rs, rt, rd, sa);
      12: w = rtype(mseu_pkg::FN_DIV, rs, ($urandom_range(0, 5) == 0) ? 5'd0 : rt, rd, sa);
      13: w = rtype(mseu_pkg::FN_JR, rs, rt, rd, sa);
      14, 15: w = itype(mseu_pkg::OP_ADDI, rs, rt, imm);
      16: w = itype(mseu_pkg::OP_LUI, rs, rt, imm);
      17, 18: w = itype(mseu_pkg::OP_SW, rs, rt, imm);
      19, 20: begin
        if (dmem_used.size() == 0) begin
          w = itype(mseu_pkg::OP_SW, rs, rt, imm);
        end else begin
          k = dmem_used[$urandom_range(0, dmem_used.size() - 1)];
          imm[11:0] = 12'(((k << 2) | $urandom_range(0, 3)) - gpr[rs]);
          w = itype(mseu_pkg::OP_LW, rs, rt, imm);
        end
      end
      21: w = itype(mseu_pkg::OP_BEQ, rs, ($urandom_range(0, 1) == 0) ? rs : rt, imm);
      22: w = itype(mseu_pkg::OP_BNE, rs, rt, imm);
      23: w = itype(mseu_pkg::OP_BLEZ, rs, rt, imm);
      24: w = itype(mseu_pkg::OP_BGTZ, rs, rt, imm);
      25: w = {($urandom_range(0, 1) == 0) ? mseu_pkg::OP_J : mseu_pkg::OP_JAL,
               26'($urandom)};
      26: w = rtype(mseu_pkg::FN_SRL, 5'($urandom_range(2, 31)), rt, rd, sa);
      default: begin
        w = $urandom;
        if (w[31:26] == mseu_pkg::OP_LW) w[31:26] = mseu_pkg::OP_SW;
      end
    endcase
    return w;
  endfunction

  task automatic offer_instr(logic [31:0] w, output mseu_pkg::result_t r);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    r = execute_instr(w);
    exp_results.push_back(r);
    n_sent++;
    if (r.status == mseu_pkg::ST_DIVZ) n_div0++;
    if (r.status == mseu_pkg::ST_REFUSE) n_refused++;
    if (r.status == mseu_pkg::ST_UNK) n_unknown++;
    k_gap: begin
      gap = $urandom_range(0, 99);
      if (gap < 60) gap = 0;
      else if (gap < 95) gap = $urandom_range(1, 4);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (exp_results.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    refuse_jumps = v;
  endtask

  typedef struct {
    logic [31:0] instr;
    bit          has_st;
    logic [1:0]  st;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{itype(mseu_pkg::OP_ADDI, 5'd0, 5'd1, 16'hffff), 1, mseu_pkg::ST_OK},
    '{itype(mseu_pkg::OP_LUI, 5'd0, 5'd2, 16'h8000), 1, mseu_pkg::ST_OK},
    '{itype(mseu_pkg::OP_ADDI, 5'd0, 5'd3, 16'h7fff), 1, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_ADD, 5'd1, 5'd2, 5'd4, 5'd0), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_SUB, 5'd2, 5'd1, 5'd5, 5'd0), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_AND, 5'd1, 5'd2, 5'd13, 5'd0), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_OR, 5'd3, 5'd2, 5'd14, 5'd0), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_XOR, 5'd1, 5'd3, 5'd15, 5'd0), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_SLT, 5'd2, 5'd3, 5'd6, 5'd0), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_SLL, 5'd0, 5'd1, 5'd7, 5'd31), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_SRL, 5'd0, 5'd2, 5'd8, 5'd31), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_SRL, 5'd1, 5'd2, 5'd9, 5'd4), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_SRL, 5'd2, 5'd2, 5'd9, 5'd4), 1, mseu_pkg::ST_UNK},
    '{rtype(mseu_pkg::FN_MULT, 5'd2, 5'd2, 5'd0, 5'd0), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_MFHI, 5'd0, 5'd0, 5'd10, 5'd0), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_MFLO, 5'd0, 5'd0, 5'd11, 5'd0), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_DIV, 5'd2, 5'd1, 5'd0, 5'd0), 0, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0), 1, mseu_pkg::ST_DIVZ},
    '{itype(mseu_pkg::OP_SW, 5'd0, 5'd1, 16'h0000), 1, mseu_pkg::ST_OK},
    '{itype(mseu_pkg::OP_LW, 5'd0, 5'd12, 16'h0003), 1, mseu_pkg::ST_OK},
    '{itype(mseu_pkg::OP_ADDI, 5'd0, 5'd0, 16'h0005), 1, mseu_pkg::ST_OK},
    '{itype(mseu_pkg::OP_BEQ, 5'd0, 5'd0, 16'hffff), 1, mseu_pkg::ST_OK},
    '{itype(mseu_pkg::OP_BNE, 5'd1, 5'd0, 16'h7fff), 1, mseu_pkg::ST_OK},
    '{itype(mseu_pkg::OP_BGTZ, 5'd3, 5'd0, 16'h8000), 1, mseu_pkg::ST_OK},
    '{itype(mseu_pkg::OP_BLEZ, 5'd2, 5'd0, 16'h0001), 1, mseu_pkg::ST_OK},
    '{{mseu_pkg::OP_J, 26'h3ffffff}, 1, mseu_pkg::ST_OK},
    '{{mseu_pkg::OP_JAL, 26'h0000000}, 1, mseu_pkg::ST_OK},
    '{rtype(mseu_pkg::FN_JR, 5'd1, 5'd0, 5'd0, 5'd0), 1, mseu_pkg::ST_OK},
    '{32'hffffffff, 1, mseu_pkg::ST_UNK},
    '{rtype(6'h3f, 5'd1, 5'd2, 5'd3, 5'd0), 1, mseu_pkg::ST_UNK}
  };

  // result side: random back-pressure with free-running stretches and one long hold
  int hold_left = 0;
  int free_left = 0;
  bit long_hold_done = 0;

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, e, a);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    mseu_pkg::result_t e;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      n_seen++;
      if (exp_results.size() == 0) begin
        $error("result item with nothing expected");
        n_fail++;
      end else begin
        e = exp_results.pop_front();
        check_field("status", 32'(e.status), 32'(out_tdata[1:0]));
        check_field("next_pc", e.next_pc, out_tdata[33:2]);
        check_field("reg_written", 32'(e.reg_written), 32'(out_tdata[34]));
        check_field("reg_index", 32'(e.reg_index), 32'(out_tdata[39:35]));
        check_field("reg_value", e.reg_value, out_tdata[71:40]);
        check_field("hi_value", e.hi_value, out_tdata[103:72]);
        check_field("lo_value", e.lo_value, out_tdata[135:104]);
        check_field("mem_written", 32'(e.mem_written), 32'(out_tdata[136]));
        check_field("mem_address", e.mem_address, out_tdata[168:137]);
        check_field("mem_data", e.mem_data, out_tdata[200:169]);
      end
    end
  end

  always @(posedge clk) begin
    int pick;
    if (!long_hold_done && n_seen >= 500) begin
      long_hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (free_left > 0) begin
      free_left--;
      out_tready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 2) free_left = $urandom_range(100, 300);
      else if (pick < 5) hold_left = $urandom_range(15, 60);
      out_tready <= (pick >= 30);
    end
  end

  initial begin
    mseu_pkg::result_t r;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    hi_q = '0; lo_q = '0; pc_q = '0; refuse_jumps = 1'b0;
    for (int i = 0; i < DMEM_WORDS; i++) begin dmem[i] = '0; dmem_set[i] = 1'b0; end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_mode(1'b0);
    foreach (dir_rows[i]) begin
      offer_instr(dir_rows[i].instr, r);
      if (dir_rows[i].has_st && r.status !== dir_rows[i].st) begin
        $error("row %0d status: expected %0d, got %0d", i, dir_rows[i].st, r.status);
        n_fail++;
      end
    end
    drain_and_settle();

    for (int p = 0; p < N_PHASES; p++) begin
      write_mode(p[0] == 1'b0);
      repeat (PHASE_LEN) offer_instr(rand_instr(), r);
      drain_and_settle();
    end

    $display("%0d items sent, %0d results checked over %0d mode settings", n_sent, n_seen,
             N_PHASES + 1);
    $display("divide by zero %0d, refused %0d, unknown %0d", n_div0, n_refused, n_unknown);
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
